@@ hdl/tbs_pkg.sv @@
// Shared constants, register codes and item types of the token bucket shaper.
package tbs_pkg;

  // Default fixed point format and time counter width.
  localparam int FRAC_BITS  = 16;
  localparam int TIME_WIDTH = 48;

  // Field widths of the configuration registers and the items.
  localparam int BUCKET_W   = 24;
  localparam int RATE_W     = 32;
  localparam int NOW_W      = 48;
  localparam int PKT_W      = 17;
  localparam int WAIT_W     = 32;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;

  // The refill product is built from this many elapsed-time bits per cycle.
  localparam int MUL_CHUNK = 16;

  // Default step counts of the multiplier and divider sequences.
  localparam int MUL_STEPS = (BUCKET_W + FRAC_BITS + MUL_CHUNK - 1) / MUL_CHUNK;
  localparam int DIV_STEPS = PKT_W + FRAC_BITS;

  // Reset values and saturation limit.
  localparam logic [BUCKET_W-1:0] BUCKET_RESET = 24'd16384;
  localparam logic [RATE_W-1:0]   RATE_RESET   = 32'd65536;
  localparam logic [WAIT_W-1:0]   WAIT_MAX     = '1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_BUCKET_SIZE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TOKEN_RATE  = 1'd1;

  // One send attempt.
  typedef struct packed {
    logic [NOW_W-1:0] now_ticks;
    logic [PKT_W-1:0] packet_bits;
  } in_t;

  // One shaping decision.
  typedef struct packed {
    logic                conform;
    logic [WAIT_W-1:0]   wait_ticks;
    logic [BUCKET_W-1:0] tokens_left;
  } out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic mul_step;
    logic refill;
    logic decide;
    logic div_step;
    logic out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic fits;
    logic rate_zero;
  } status_t;

endpackage

@@ hdl/tbs_ctrl.sv @@
// Sequencing state machine of the token bucket shaper.
module tbs_ctrl #(
  parameter int MUL_STEPS = tbs_pkg::MUL_STEPS,
  parameter int DIV_STEPS = tbs_pkg::DIV_STEPS
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              out_free_i,
  input  tbs_pkg::status_t  status_i,
  output tbs_pkg::cmd_t     cmd_o,
  output logic              busy_o
);

  localparam int CNT_W = $clog2(DIV_STEPS);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_MUL    = 3'd1;
  localparam logic [2:0] ST_REFILL = 3'd2;
  localparam logic [2:0] ST_DECIDE = 3'd3;
  localparam logic [2:0] ST_DIV    = 3'd4;
  localparam logic [2:0] ST_FINISH = 3'd5;

  logic [2:0]       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  // Next state, step counter and datapath commands.
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          cnt_d      = '0;
          state_d    = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd_o.mul_step = 1'b1;
        if (cnt_q == CNT_W'(MUL_STEPS - 1)) begin
          cnt_d   = '0;
          state_d = ST_REFILL;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_REFILL: begin
        cmd_o.refill = 1'b1;
        state_d      = ST_DECIDE;
      end
      ST_DECIDE: begin
        cmd_o.decide = 1'b1;
        cnt_d        = '0;
        if (status_i.fits || status_i.rate_zero) begin
          state_d = ST_FINISH;
        end else begin
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
          state_d = ST_FINISH;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_FINISH: begin
        if (out_free_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign busy_o = (state_q != ST_IDLE);

  // State registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

@@ hdl/tbs_datapath.sv @@
// Token level, refill multiplier and retry-delay divider of the shaper.
module tbs_datapath #(
  parameter int FRAC_BITS  = tbs_pkg::FRAC_BITS,
  parameter int TIME_WIDTH = tbs_pkg::TIME_WIDTH
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  tbs_pkg::cmd_t                  cmd_i,
  input  tbs_pkg::in_t                   in_i,
  input  logic [tbs_pkg::BUCKET_W-1:0]   bucket_i,
  input  logic [tbs_pkg::RATE_W-1:0]     rate_i,
  output tbs_pkg::status_t               status_o,
  output tbs_pkg::out_t                  res_o
);

  localparam int LEVEL_W   = tbs_pkg::BUCKET_W + FRAC_BITS;
  localparam int CHUNK     = tbs_pkg::MUL_CHUNK;
  localparam int MUL_STEPS = (LEVEL_W + CHUNK - 1) / CHUNK;
  localparam int EL_W      = MUL_STEPS * CHUNK;
  localparam int RATE_W    = tbs_pkg::RATE_W;
  localparam int ACC_W     = LEVEL_W + RATE_W;
  localparam int NUM_W     = tbs_pkg::PKT_W + FRAC_BITS;
  localparam int WAIT_W    = tbs_pkg::WAIT_W;

  // Bucket state.
  logic [LEVEL_W-1:0]    level_q, level_d;
  logic [TIME_WIDTH-1:0] last_q, last_d;

  // Per-item working registers.
  logic [EL_W-1:0]             el_q, el_d;
  logic                        sat_q, sat_d;
  logic [ACC_W-1:0]            acc_q, acc_d;
  logic [tbs_pkg::PKT_W-1:0]   pkt_q, pkt_d;
  logic                        conform_q, conform_d;
  logic [NUM_W-1:0]            nq_q, nq_d;
  logic [RATE_W-1:0]           rem_q, rem_d;

  logic [63:0]             now_wide;
  logic [TIME_WIDTH-1:0]   now_tw;
  logic [TIME_WIDTH-1:0]   elapsed;
  logic [63:0]             el_wide;
  logic                    el_hi;
  logic [CHUNK+RATE_W-1:0] pp;
  logic [LEVEL_W-1:0]      cap;
  logic [ACC_W:0]          sum;
  logic [NUM_W-1:0]        need;
  logic                    fits;
  logic                    rate_zero;
  logic [RATE_W:0]         rem_sh;
  logic [RATE_W:0]         rem_sub;
  logic                    rem_ge;
  logic [63:0]             q_wide;
  logic                    q_sat;

  // Elapsed time wraps like the time counter; a gap beyond the level width
  // always saturates a nonzero rate.
  assign now_wide  = 64'(in_i.now_ticks);
  assign now_tw    = now_wide[TIME_WIDTH-1:0];
  assign elapsed   = now_tw - last_q;
  assign el_wide   = 64'(elapsed);
  assign el_hi     = (el_wide >> LEVEL_W) != 64'd0;
  assign rate_zero = (rate_i == '0);

  // Refill product, most significant chunk of elapsed time first.
  assign pp  = el_q[EL_W-1 -: CHUNK] * rate_i;
  assign cap = {bucket_i, {FRAC_BITS{1'b0}}};
  assign sum = (ACC_W+1)'(level_q) + (ACC_W+1)'(acc_q);

  // Conformance test against the packet length in fixed point.
  assign need = {pkt_q, {FRAC_BITS{1'b0}}};
  assign fits = (level_q >= LEVEL_W'(need));

  // One restoring division step per cycle.
  assign rem_sh  = {rem_q, nq_q[NUM_W-1]};
  assign rem_ge  = (rem_sh >= {1'b0, rate_i});
  assign rem_sub = rem_sh - {1'b0, rate_i};

  always_comb begin
    level_d   = level_q;
    last_d    = last_q;
    el_d      = el_q;
    sat_d     = sat_q;
    acc_d     = acc_q;
    pkt_d     = pkt_q;
    conform_d = conform_q;
    nq_d      = nq_q;
    rem_d     = rem_q;
    if (cmd_i.load) begin
      last_d = now_tw;
      el_d   = EL_W'(el_wide[LEVEL_W-1:0]);
      sat_d  = el_hi && !rate_zero;
      acc_d  = '0;
      pkt_d  = in_i.packet_bits;
    end
    if (cmd_i.mul_step) begin
      acc_d = (acc_q << CHUNK) + ACC_W'(pp);
      el_d  = el_q << CHUNK;
    end
    if (cmd_i.refill) begin
      if (sat_q || (sum > (ACC_W+1)'(cap))) begin
        level_d = cap;
      end else begin
        level_d = sum[LEVEL_W-1:0];
      end
    end
    if (cmd_i.decide) begin
      conform_d = fits;
      nq_d      = need;
      rem_d     = '0;
      if (fits) begin
        level_d = level_q - LEVEL_W'(need);
      end
    end
    if (cmd_i.div_step) begin
      nq_d  = {nq_q[NUM_W-2:0], rem_ge};
      rem_d = rem_ge ? rem_sub[RATE_W-1:0] : rem_sh[RATE_W-1:0];
    end
  end

  // Bucket state starts full at the reset capacity.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q <= LEVEL_W'(tbs_pkg::BUCKET_RESET) << FRAC_BITS;
      last_q  <= '0;
    end else begin
      level_q <= level_d;
      last_q  <= last_d;
    end
  end

  // Working registers carry payload only.
  always_ff @(posedge clk_i) begin
    el_q      <= el_d;
    sat_q     <= sat_d;
    acc_q     <= acc_d;
    pkt_q     <= pkt_d;
    conform_q <= conform_d;
    nq_q      <= nq_d;
    rem_q     <= rem_d;
  end

  // Result: the quotient saturates, and a zero rate means an endless wait.
  assign q_wide = 64'(nq_q);
  assign q_sat  = rate_zero || (q_wide[63:WAIT_W] != '0);

  always_comb begin
    res_o.conform     = conform_q;
    res_o.tokens_left = level_q[LEVEL_W-1:FRAC_BITS];
    if (conform_q) begin
      res_o.wait_ticks = '0;
    end else if (q_sat) begin
      res_o.wait_ticks = tbs_pkg::WAIT_MAX;
    end else begin
      res_o.wait_ticks = q_wide[WAIT_W-1:0];
    end
  end

  assign status_o.fits      = fits;
  assign status_o.rate_zero = rate_zero;

endmodule

@@ hdl/token_bucket_shaper_unit.sv @@
// An accepted item runs through the refill multiply, the refill and the conformance decision;
// a refused packet at a nonzero rate then goes through the restoring divider, which retires
// one quotient bit per cycle, before its result enters the output register.
// The shaper takes one item at a time; the next is taken once
// the result enters the output register, which holds it while the consumer stalls. Reset
// empties the pipeline, loads the register reset values and fills the bucket at time zero.
module token_bucket_shaper_unit #(
  parameter int FRAC_BITS  = tbs_pkg::FRAC_BITS,
  parameter int TIME_WIDTH = tbs_pkg::TIME_WIDTH
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  tbs_pkg::in_t                     in_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output tbs_pkg::out_t                    out_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [tbs_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [tbs_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  localparam int LEVEL_W   = tbs_pkg::BUCKET_W + FRAC_BITS;
  localparam int MUL_STEPS = (LEVEL_W + tbs_pkg::MUL_CHUNK - 1) / tbs_pkg::MUL_CHUNK;
  localparam int DIV_STEPS = tbs_pkg::PKT_W + FRAC_BITS;

  logic [tbs_pkg::BUCKET_W-1:0] bucket_q, bucket_d;
  logic [tbs_pkg::RATE_W-1:0]   rate_q, rate_d;
  logic                         out_valid_q, out_valid_d;
  tbs_pkg::out_t                out_q;
  tbs_pkg::out_t                res;
  tbs_pkg::cmd_t                cmd;
  tbs_pkg::status_t             status;
  logic                         busy;
  logic                         out_free;

  // Configuration registers take a write in any cycle.
  assign cfg_ready_o = 1'b1;

  always_comb begin
    bucket_d = bucket_q;
    rate_d   = rate_q;
    if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        tbs_pkg::REG_BUCKET_SIZE: bucket_d = cfg_data_i[tbs_pkg::BUCKET_W-1:0];
        tbs_pkg::REG_TOKEN_RATE:  rate_d   = cfg_data_i[tbs_pkg::RATE_W-1:0];
        default: begin
          bucket_d = bucket_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bucket_q <= tbs_pkg::BUCKET_RESET;
      rate_q   <= tbs_pkg::RATE_RESET;
    end else begin
      bucket_q <= bucket_d;
      rate_q   <= rate_d;
    end
  end

  // The output register is free when empty or being taken this cycle.
  assign out_free = !out_valid_q || !out_stall_i;

  tbs_ctrl #(
    .MUL_STEPS (MUL_STEPS),
    .DIV_STEPS (DIV_STEPS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .out_free_i (out_free),
    .status_i   (status),
    .cmd_o      (cmd),
    .busy_o     (busy)
  );

  tbs_datapath #(
    .FRAC_BITS  (FRAC_BITS),
    .TIME_WIDTH (TIME_WIDTH)
  ) u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .in_i     (in_i),
    .bucket_i (bucket_q),
    .rate_i   (rate_q),
    .status_o (status),
    .res_o    (res)
  );

  assign in_stall_o = busy;

  // Output register holding the finished item.
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd.out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd.out_load) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  // An accepted item keeps the input closed on the following cycle.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input accepted while an item is in progress");

  // A conforming item never reports a retry delay.
  a_conform_no_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_o.conform) |-> (out_o.wait_ticks == '0))
    else $error("conforming item carries a nonzero wait");

  // Tokens left never exceed the bucket capacity.
  a_level_capped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_o.tokens_left <= bucket_q))
    else $error("tokens left exceed bucket size");

  // With a zero rate a refused packet waits forever.
  a_zero_rate_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_o.conform && (rate_q == '0))
      |-> (out_o.wait_ticks == tbs_pkg::WAIT_MAX))
    else $error("zero rate without saturated wait");

endmodule

@@ tb/sv/token_bucket_shaper_unit_tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench of the token bucket shaper: directed corners and random traffic against a built-in predictor.
module token_bucket_shaper_unit_tb;
  import tbs_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int HOLD_CYCLES   = 300;
  localparam int END_CYCLES    = 60;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_ITEMS   = 135;
  localparam int MAX_REPORTS   = 10;
  localparam int LEVEL_W       = BUCKET_W + FRAC_BITS;
  localparam int PKT_MAX       = (1 << PKT_W) - 1;

  bit                    clk_i;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_stall_o;
  in_t                   in_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  out_t                  out_o;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  // Shadow copy of the shaper registers and bucket state.
  logic [BUCKET_W-1:0]   shadow_bucket;
  logic [RATE_W-1:0]     shadow_rate;
  logic [LEVEL_W-1:0]    shadow_level;
  logic [TIME_WIDTH-1:0] shadow_last;

  // Send attempts waiting to be driven and decisions waiting to come out.
  in_t  attempts_q[$];
  out_t decisions_due[$];

  logic [NOW_W-1:0] t_cursor;
  in_t              tx_item;
  bit               tx_busy;
  bit               tx_calm;
  int unsigned      tx_gap;
  bit               in_taken;
  bit               out_taken;
  bit               rx_calm;
  bit               hold_rx;
  int unsigned      rx_wait;
  int unsigned      n_accepted;
  int unsigned      n_decisions;
  int unsigned      n_errors;
  int unsigned      hold_reqs;
  int unsigned      hold_served;
  int unsigned      cycles;

  token_bucket_shaper_unit u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_i        (in_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Refill the shadow bucket for one attempt and decide whether the packet may go.
  function automatic out_t grant_decision(input in_t att);
    logic [63:0]           cap;
    logic [63:0]           elapsed;
    logic [63:0]           add;
    logic [63:0]           level;
    logic [63:0]           need;
    logic [63:0]           quot;
    logic [TIME_WIDTH-1:0] gap;
    out_t                  dec;
    cap = 64'(shadow_bucket) << FRAC_BITS;
    gap = att.now_ticks[TIME_WIDTH-1:0] - shadow_last;
    elapsed = 64'(gap);
    if (shadow_rate == '0) begin
      add = '0;
    end else if (elapsed > cap / 64'(shadow_rate)) begin
      add = cap;
    end else begin
      add = 64'(shadow_rate) * elapsed;
    end
    level = 64'(shadow_level) + add;
    if (level > cap) begin
      level = cap;
    end
    shadow_last = att.now_ticks[TIME_WIDTH-1:0];
    need = 64'(att.packet_bits) << FRAC_BITS;
    dec = '0;
    if (level >= need) begin
      level = level - need;
      dec.conform = 1'b1;
    end else if (shadow_rate == '0) begin
      dec.wait_ticks = WAIT_MAX;
    end else begin
      quot = need / 64'(shadow_rate);
      dec.wait_ticks = (quot > 64'(WAIT_MAX)) ? WAIT_MAX : quot[WAIT_W-1:0];
    end
    shadow_level = level[LEVEL_W-1:0];
    dec.tokens_left = level[FRAC_BITS +: BUCKET_W];
    return dec;
  endfunction

  function automatic void flag_error(input string msg);
    n_errors++;
    if (n_errors <= MAX_REPORTS) begin
      $display("%s", msg);
    end
  endfunction

  // Predict on every accepted attempt and check every accepted decision.
  always @(posedge clk_i) begin : decision_check
    out_t due;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      decisions_due.push_back(grant_decision(in_i));
      in_taken = 1'b1;
      n_accepted++;
      if (n_accepted % 64 == 0) begin
        tx_calm = ($urandom_range(0, 3) == 0);
      end
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      out_taken = 1'b1;
      n_decisions++;
      if (n_decisions % 64 == 0) begin
        rx_calm = ($urandom_range(0, 3) == 0);
      end
      if (decisions_due.size() == 0) begin
        flag_error($sformatf("%0t: decision with none pending: conform %0b wait %0d left %0d",
                             $time, out_o.conform, out_o.wait_ticks, out_o.tokens_left));
      end else begin
        due = decisions_due.pop_front();
        if (out_o.conform !== due.conform || out_o.wait_ticks !== due.wait_ticks ||
            out_o.tokens_left !== due.tokens_left) begin
          flag_error($sformatf({"%0t: decision mismatch: expected conform %0b wait %0d left %0d,",
                                " got conform %0b wait %0d left %0d"}, $time,
                               due.conform, due.wait_ticks, due.tokens_left,
                               out_o.conform, out_o.wait_ticks, out_o.tokens_left));
        end
      end
    end
  end

  // Sender: present queued attempts with a random gap before each item.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_taken) begin
        in_taken = 1'b0;
        tx_busy = 1'b0;
        tx_gap = tx_calm ? 0 : $urandom_range(0, 3);
      end
      if (!tx_busy && attempts_q.size() != 0) begin
        if (tx_gap != 0) begin
          tx_gap--;
        end else begin
          tx_item = attempts_q.pop_front();
          tx_busy = 1'b1;
        end
      end
      in_valid_i <= tx_busy;
      in_i       <= tx_item;
    end
  end

  // Receiver: stall each decision for a random number of cycles, or hold off entirely.
  always @(negedge clk_i) begin : decision_sink
    bit stall_now;
    if (out_taken) begin
      out_taken = 1'b0;
      rx_wait = rx_calm ? 0 : $urandom_range(0, 3);
    end
    stall_now = hold_rx || rx_wait != 0;
    if (out_valid_o && !hold_rx && rx_wait != 0) begin
      rx_wait--;
    end
    out_stall_i <= stall_now;
  end

  // Long receiver hold-offs on request, so the shaper backs up into its input.
  initial begin
    forever begin
      while (hold_reqs == hold_served) @(posedge clk_i);
      hold_rx = 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk_i);
      hold_rx = 1'b0;
      hold_served++;
    end
  end

  // Run limit.
  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("token_bucket_shaper_unit_tb: errors");
    $finish;
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    if (idx == REG_BUCKET_SIZE) begin
      shadow_bucket = data[BUCKET_W-1:0];
    end else if (idx == REG_TOKEN_RATE) begin
      shadow_rate = data[RATE_W-1:0];
    end
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_shaping(input logic [CFG_DATA_W-1:0] bucket_word,
                             input logic [CFG_DATA_W-1:0] rate_word);
    write_reg(REG_BUCKET_SIZE, bucket_word);
    write_reg(REG_TOKEN_RATE, rate_word);
  endtask

  // Wait until every queued attempt has been taken and its decision checked.
  task automatic wait_idle();
    @(posedge clk_i);
    while (attempts_q.size() != 0 || tx_busy || decisions_due.size() != 0) @(posedge clk_i);
  endtask

  task automatic offer(input logic [NOW_W-1:0] now, input logic [PKT_W-1:0] bits);
    in_t att;
    att.now_ticks   = now;
    att.packet_bits = bits;
    attempts_q.push_back(att);
    t_cursor = now;
  endtask

  // Traffic sized to the current bucket and rate, with jumps and steps back in time.
  task automatic run_random_phase(input int n_items);
    int unsigned      pkt_hi;
    int unsigned      span;
    int unsigned      sel;
    longint unsigned  span_l;
    logic [NOW_W-1:0] now;
    logic [PKT_W-1:0] bits;
    pkt_hi = 32'(shadow_bucket) / 2;
    if (pkt_hi > PKT_MAX) begin
      pkt_hi = PKT_MAX;
    end
    if (pkt_hi == 0) begin
      pkt_hi = 1;
    end
    if (shadow_rate == '0) begin
      span_l = 4096;
    end else begin
      span_l = ((longint'(pkt_hi) << FRAC_BITS) / longint'(shadow_rate)) + 1;
    end
    span = (span_l > 1000000) ? 1000000 : int'(span_l);
    repeat (n_items) begin
      now = t_cursor;
      sel = $urandom_range(0, 99);
      if (sel < 60) begin
        now = now + $urandom_range(0, span);
      end else if (sel < 80) begin
        now = now + $urandom_range(0, 16);
      end else if (sel < 88) begin
        now = NOW_W'({$urandom, $urandom});
      end else if (sel < 94) begin
        now = now - $urandom_range(1, 4096);
      end
      sel = $urandom_range(0, 99);
      if (sel < 75) begin
        bits = PKT_W'($urandom_range(0, pkt_hi));
      end else if (sel < 85) begin
        bits = '0;
      end else begin
        bits = PKT_W'($urandom);
      end
      offer(now, bits);
    end
  endtask

  // Stimulus: directed corners first, then random phases under changing settings.
  initial begin
    int unsigned           sel;
    logic [BUCKET_W-1:0]   bkt;
    logic [CFG_DATA_W-1:0] bucket_word;
    logic [CFG_DATA_W-1:0] rate_word;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_i        = '0;
    out_stall_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = REG_BUCKET_SIZE;
    cfg_data_i  = '0;
    shadow_bucket = BUCKET_RESET;
    shadow_rate   = RATE_RESET;
    shadow_level  = LEVEL_W'(BUCKET_RESET) << FRAC_BITS;
    shadow_last   = '0;
    t_cursor      = '0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset setting: empty and oversized packets, draining, time at its top and going back.
    offer(48'd0, 17'd0);
    offer(48'd0, 17'd131071);
    offer(48'd0, 17'd16384);
    offer(48'd1, 17'd1);
    offer(48'd1, 17'd1);
    offer(48'd200, 17'd150);
    offer({NOW_W{1'b1}}, 17'd0);
    offer(48'd5, 17'd17);
    offer(48'd5, 17'd0);
    offer(48'hAAAA_AAAA_AAAA, 17'h0AAAA);
    offer(48'h5555_5555_5555, 17'h15555);
    wait_idle();

    // Largest bucket with no refill: waits saturate at the maximum.
    set_shaping(32'hFFFF_FFFF, 32'h0);
    offer(t_cursor, 17'd0);
    offer(t_cursor, 17'd131071);
    offer(t_cursor, 17'd16284);
    offer(t_cursor, 17'd101);
    offer(t_cursor + 48'd1000, 17'd0);
    wait_idle();

    // Shrunk bucket with the fastest rate: the held level is clamped on the next attempt.
    set_shaping(32'h0000_000A, 32'hFFFF_FFFF);
    offer(t_cursor, 17'd0);
    offer(t_cursor, 17'd11);
    offer(t_cursor, 17'd10);
    offer(t_cursor + 48'd1, 17'd10);
    wait_idle();

    // Slowest nonzero rate: the retry delay overflows and saturates.
    set_shaping(32'h0000_03E8, 32'h0000_0001);
    offer(t_cursor + 48'd3, 17'd131071);
    offer(t_cursor + 48'd327680, 17'd4);
    wait_idle();

    // Zero capacity: only an empty packet conforms.
    set_shaping(32'h0000_0000, RATE_RESET);
    offer(t_cursor + 48'd10, 17'd1);
    offer(t_cursor, 17'd0);

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      wait_idle();
      sel = $urandom_range(0, 9);
      if (sel == 0) begin
        bkt = '0;
      end else if (sel == 1) begin
        bkt = '1;
      end else if (sel == 2) begin
        bkt = BUCKET_W'($urandom);
      end else begin
        bkt = BUCKET_W'($urandom_range(64, 150000));
      end
      bucket_word = $urandom;
      bucket_word[BUCKET_W-1:0] = bkt;
      sel = $urandom_range(0, 9);
      if (sel == 0) begin
        rate_word = '0;
      end else if (sel == 1) begin
        rate_word = 32'h1;
      end else if (sel == 2) begin
        rate_word = '1;
      end else if (sel == 3) begin
        rate_word = $urandom;
      end else begin
        rate_word = $urandom_range(4096, 524288);
      end
      set_shaping(bucket_word, rate_word);
      run_random_phase(PHASE_ITEMS);
      if (ph == 2 || ph == 5) begin
        hold_reqs++;
      end
    end

    wait_idle();
    repeat (END_CYCLES) @(posedge clk_i);
    if (n_errors == 0 && decisions_due.size() == 0) begin
      $display("token_bucket_shaper_unit_tb: clean");
    end else begin
      $display("token_bucket_shaper_unit_tb: errors");
    end
    $finish;
  end

endmodule
